@@ sv/hbcp_pkg.sv @@
package hbcp_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int QSHIFT     = ANGLE_BITS - 2;
  localparam int QN         = 1 << QSHIFT;
  localparam int QIDX_W     = QSHIFT + 1;

  localparam int NREG       = 6;
  localparam int ADDR_W     = 6;
  localparam int QBITS      = 17;
  localparam int REM_W      = 82;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [63:0] REG_RESET [NREG] = '{
    64'd65536000,
    64'd62914560,
    64'd281474976710656000,
    64'd35389440,
    64'd0,
    64'd65536
  };

  typedef logic [15:0] qmag_t;
  typedef qmag_t qtab_t [QN + 1];

  // 3x4 projection matrix, [row][col], signed Q16.16 held as raw bits
  typedef logic [2:0][3:0][31:0] mat_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         idx;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic [15:0]        h;
    logic [15:0]        w;
    logic [15:0]        l;
    logic signed [16:0] s;
    logic signed [16:0] c;
  } corner_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         idx;
    logic signed [63:0] acc0;
    logic signed [63:0] acc1;
    logic signed [63:0] acc2;
  } geom_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         idx;
    logic               ok;
    logic               neg_u;
    logic               neg_v;
    logic [REM_W-1:0]   rem_u;
    logic [REM_W-1:0]   rem_v;
    logic [64:0]        d2;
    logic [QBITS-1:0]   q_u;
    logic [QBITS-1:0]   q_v;
  } div_stage_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         idx;
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic               skip;
  } res_t;

  // shift-subtract quotient, used only while building the table at elaboration
  function automatic logic [63:0] elab_udiv(logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // quarter-wave sine magnitudes in units of 2^-15, built at elaboration
  function automatic qtab_t gen_qtab();
    qtab_t              t;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    logic [63:0]        dv;
    for (int k = 0; k <= QN; k++) begin
      x    = (HALF_PI_Q30 * 64'(k) + 64'((1 << QSHIFT) >> 1)) >> QSHIFT;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 8; n++) begin
        dv   = 64'((2 * n) * (2 * n + 1));
        term = elab_udiv((term * x2) >> 30, dv);
        if (n % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        t[k] = '0;
      end else begin
        r = (64'(sum) + 64'd16384) >> 15;
        t[k] = (r > 64'd32768) ? 16'd32768 : r[15:0];
      end
    end
    return t;
  endfunction

  localparam qtab_t QTAB = gen_qtab();

  // one restoring step of the u/v divider, quotient bit k
  function automatic div_stage_t div_step(div_stage_t s, int k);
    div_stage_t       o;
    logic [REM_W-1:0] dsh;
    logic [REM_W:0]   du;
    logic [REM_W:0]   dv;
    o   = s;
    dsh = REM_W'(s.d2) << k;
    du  = {1'b0, s.rem_u} - {1'b0, dsh};
    dv  = {1'b0, s.rem_v} - {1'b0, dsh};
    if (!du[REM_W]) begin
      o.rem_u = du[REM_W-1:0];
      o.q_u   = s.q_u | (QBITS'(1) << k);
    end
    if (!dv[REM_W]) begin
      o.rem_v = dv[REM_W-1:0];
      o.q_v   = s.q_v | (QBITS'(1) << k);
    end
    return o;
  endfunction

  function automatic logic signed [15:0] sat_pix(logic [QBITS-1:0] q, logic neg);
    logic signed [15:0] r;
    if (neg) begin
      r = (q > QBITS'(32768)) ? -16'sd32768 : 16'(QBITS'(0) - q);
    end else begin
      r = (q > QBITS'(32767)) ? 16'sd32767 : q[15:0];
    end
    return r;
  endfunction

endpackage

@@ sv/hbcp_in_if.sv @@
interface hbcp_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] pos_z;
  logic [15:0]        box_height;
  logic [15:0]        box_width;
  logic [15:0]        box_length;
  logic [11:0]        heading_angle;

  modport source (output valid, pos_x, pos_y, pos_z, box_height, box_width, box_length,
                  heading_angle, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, box_height, box_width, box_length,
                heading_angle, output ready);
endinterface

@@ sv/hbcp_out_if.sv @@
interface hbcp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         corner_index;
  logic signed [15:0] pixel_u;
  logic signed [15:0] pixel_v;
  logic               skipped;
  logic               last;

  modport source (output valid, corner_index, pixel_u, pixel_v, skipped, last, input ready);
  modport sink (input valid, corner_index, pixel_u, pixel_v, skipped, last, output ready);
endinterface

@@ sv/heading_box_corner_projection.sv @@
// Projects a heading-rotated 3D box into the image: each accepted box gives eight corner
// beats (corner_index 0..7, last on corner 7), or one skipped beat when any corner has
// depth <= 0. The sequencer walks the corners of a box one per cycle, unless the output stalls,
// through the shared rotate, matrix and divide pipeline, and can take the next box while
// it issues the last corner of the current one; corners leave one per cycle while the sink
// is ready. The divider works one quotient bit per stage, and a box is held until all
// its corners are in. Two box buffers at the output let the next box flow while the last
// one drains. Write the matrix registers only while no box is in flight.
module heading_box_corner_projection
  import hbcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  hbcp_in_if.sink           in_box,
  hbcp_out_if.source        out_corner,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  mat_t    mat;
  corner_t corner;
  geom_t   geom;
  res_t    res;
  logic    stall;
  logic    en;

  assign en = !stall;

  hbcp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mat     (mat)
  );

  hbcp_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_box (in_box),
    .corner (corner)
  );

  hbcp_geom u_geom (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .mat    (mat),
    .corner (corner),
    .geom   (geom)
  );

  hbcp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .geom (geom),
    .res  (res)
  );

  hbcp_collect u_collect (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .stall      (stall),
    .out_corner (out_corner)
  );

endmodule

@@ sv/hbcp_regs.sv @@
module hbcp_regs
  import hbcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output mat_t              mat
);

  logic [63:0] regs [NREG];
  logic [2:0]  ridx;

  assign ridx   = paddr[ADDR_W-1:3];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREG; i++) begin
        regs[i] <= REG_RESET[i];
      end
    end else if (psel && penable && pwrite && (ridx < 3'(NREG))) begin
      regs[ridx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (ridx < 3'(NREG)) begin
      prdata = regs[ridx];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mat[r][0] = regs[2*r][31:0];
      mat[r][1] = regs[2*r][63:32];
      mat[r][2] = regs[2*r+1][31:0];
      mat[r][3] = regs[2*r+1][63:32];
    end
  end

endmodule

@@ sv/hbcp_seq.sv @@
module hbcp_seq
  import hbcp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  hbcp_in_if.sink in_box,
  output corner_t corner
);

  logic               busy;
  logic [2:0]         cnt;
  logic signed [23:0] px, py, pz;
  logic [15:0]        h, w, l;
  logic [1:0]         quad;
  qmag_t              m_r, m_n;
  logic               accept;
  logic [QSHIFT-1:0]  ang_r;
  logic signed [16:0] pos_r, pos_n;

  assign in_box.ready = en && (!busy || cnt == 3'd7);
  assign accept       = in_box.valid && in_box.ready;
  assign ang_r        = in_box.heading_angle[QSHIFT-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (en) begin
      if (accept) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // item fields and the sine table read, registered on the accepting beat
  always_ff @(posedge clk) begin
    if (accept) begin
      px   <= in_box.pos_x;
      py   <= in_box.pos_y;
      pz   <= in_box.pos_z;
      h    <= in_box.box_height;
      w    <= in_box.box_width;
      l    <= in_box.box_length;
      quad <= in_box.heading_angle[ANGLE_BITS-1 -: 2];
      m_r  <= QTAB[QIDX_W'(ang_r)];
      m_n  <= QTAB[QIDX_W'(QN) - QIDX_W'(ang_r)];
    end
  end

  assign pos_r = $signed({1'b0, m_r});
  assign pos_n = $signed({1'b0, m_n});

  always_comb begin
    corner.valid = busy;
    corner.idx   = cnt;
    corner.px    = px;
    corner.py    = py;
    corner.pz    = pz;
    corner.h     = h;
    corner.w     = w;
    corner.l     = l;
    case (quad)
      2'd0: begin
        corner.s = pos_r;
        corner.c = pos_n;
      end
      2'd1: begin
        corner.s = pos_n;
        corner.c = -pos_r;
      end
      2'd2: begin
        corner.s = -pos_r;
        corner.c = -pos_n;
      end
      default: begin
        corner.s = -pos_n;
        corner.c = pos_r;
      end
    endcase
  end

endmodule

@@ sv/hbcp_geom.sv @@
module hbcp_geom
  import hbcp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  mat_t    mat,
  input  corner_t corner,
  output geom_t   geom
);

  // stage A: rotation products
  logic               a_valid;
  logic [2:0]         a_idx;
  logic signed [23:0] a_px, a_py, a_pz;
  logic [15:0]        a_h;
  logic signed [33:0] a_cl, a_sl, a_cw, a_sw;

  // stage B: corner in camera space, units of 2^-12 m
  logic               b_valid;
  logic [2:0]         b_idx;
  logic signed [28:0] b_x, b_y, b_z;

  // stage C: matrix products
  logic               c_valid;
  logic [2:0]         c_idx;
  logic signed [60:0] cp [3][3];

  logic signed [40:0] xs, zs;
  logic signed [24:0] yd;
  logic               sxneg, szneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= corner.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_idx <= corner.idx;
      a_px  <= corner.px;
      a_py  <= corner.py;
      a_pz  <= corner.pz;
      a_h   <= corner.h;
      a_cl  <= 34'(corner.c * $signed({1'b0, corner.l}));
      a_sl  <= 34'(corner.s * $signed({1'b0, corner.l}));
      a_cw  <= 34'(corner.c * $signed({1'b0, corner.w}));
      a_sw  <= 34'(corner.s * $signed({1'b0, corner.w}));
    end
  end

  // x offset is negative on corners 2,3,6,7; z offset on 1,2,5,6
  assign sxneg = a_idx[1];
  assign szneg = a_idx[0] ^ a_idx[1];

  always_comb begin
    xs = 41'(sxneg ? -a_cl : a_cl) + 41'(szneg ? -a_sw : a_sw) + (41'(a_px) <<< 16)
         + 41'sd2048;
    zs = 41'(sxneg ? a_sl : -a_sl) + 41'(szneg ? -a_cw : a_cw) + (41'(a_pz) <<< 16)
         + 41'sd2048;
    yd = 25'(a_py) - (a_idx[2] ? 25'($signed({1'b0, a_h})) : 25'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_idx <= a_idx;
      b_x   <= xs[40:12];
      b_y   <= {yd, 4'b0000};
      b_z   <= zs[40:12];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_idx <= b_idx;
      for (int r = 0; r < 3; r++) begin
        cp[r][0] <= 61'($signed(mat[r][0]) * b_x);
        cp[r][1] <= 61'($signed(mat[r][1]) * b_y);
        cp[r][2] <= 61'($signed(mat[r][2]) * b_z);
      end
    end
  end

  // fourth column carries the translation, scaled by 2^12
  always_ff @(posedge clk) begin
    if (rst) begin
      geom.valid <= 1'b0;
    end else if (en) begin
      geom.valid <= c_valid;
    end
    if (en) begin
      geom.idx  <= c_idx;
      geom.acc0 <= 64'(cp[0][0]) + 64'(cp[0][1]) + 64'(cp[0][2])
                   + (64'($signed(mat[0][3])) <<< 12);
      geom.acc1 <= 64'(cp[1][0]) + 64'(cp[1][1]) + 64'(cp[1][2])
                   + (64'($signed(mat[1][3])) <<< 12);
      geom.acc2 <= 64'(cp[2][0]) + 64'(cp[2][1]) + 64'(cp[2][2])
                   + (64'($signed(mat[2][3])) <<< 12);
    end
  end

endmodule

@@ sv/hbcp_div.sv @@
module hbcp_div
  import hbcp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  geom_t geom,
  output res_t  res
);

  div_stage_t st [QBITS+1];
  div_stage_t prep;
  logic [63:0] mag_u, mag_v, den;

  // q = floor((2|n| + d) / 2d), which rounds half away from zero
  always_comb begin
    den        = geom.acc2;
    mag_u      = geom.acc0[63] ? 64'(-geom.acc0) : 64'(geom.acc0);
    mag_v      = geom.acc1[63] ? 64'(-geom.acc1) : 64'(geom.acc1);
    prep.valid = geom.valid;
    prep.idx   = geom.idx;
    prep.ok    = !geom.acc2[63] && (geom.acc2 != 64'sd0);
    prep.neg_u = geom.acc0[63];
    prep.neg_v = geom.acc1[63];
    prep.rem_u = REM_W'({1'b0, mag_u, 1'b0} + {2'b00, den});
    prep.rem_v = REM_W'({1'b0, mag_v, 1'b0} + {2'b00, den});
    prep.d2    = {den, 1'b0};
    prep.q_u   = '0;
    prep.q_v   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= QBITS; j++) begin
        st[j].valid <= 1'b0;
      end
    end else if (en) begin
      st[0] <= prep;
      for (int j = 0; j < QBITS; j++) begin
        st[j+1] <= div_step(st[j], QBITS - 1 - j);
      end
    end
  end

  always_comb begin
    res.valid = st[QBITS].valid;
    res.idx   = st[QBITS].idx;
    res.u     = sat_pix(st[QBITS].q_u, st[QBITS].neg_u);
    res.v     = sat_pix(st[QBITS].q_v, st[QBITS].neg_v);
    res.skip  = !st[QBITS].ok;
  end

endmodule

@@ sv/hbcp_collect.sv @@
module hbcp_collect
  import hbcp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  res_t          res,
  output logic          stall,
  hbcp_out_if.source    out_corner
);

  logic signed [15:0] bu [2][8];
  logic signed [15:0] bv [2][8];
  logic [1:0]         bskip;
  logic [1:0]         full;
  logic [1:0]         full_next;
  logic               wbank;
  logic               rbank;
  logic [2:0]         ridx;
  logic               wr;
  logic               rd_last;

  // a box is held whole until its depth check is known for all corners
  assign stall = res.valid && full[wbank];
  assign wr    = res.valid && !full[wbank];

  always_ff @(posedge clk) begin
    if (wr) begin
      bu[wbank][res.idx] <= res.u;
      bv[wbank][res.idx] <= res.v;
      if (res.idx == 3'd0) begin
        bskip[wbank] <= res.skip;
      end else begin
        bskip[wbank] <= bskip[wbank] | res.skip;
      end
    end
  end

  assign rd_last = bskip[rbank] || (ridx == 3'd7);

  always_comb begin
    full_next = full;
    if (out_corner.valid && out_corner.ready && rd_last) begin
      full_next[rbank] = 1'b0;
    end
    if (wr && res.idx == 3'd7) begin
      full_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full  <= '0;
      wbank <= 1'b0;
      rbank <= 1'b0;
      ridx  <= '0;
    end else begin
      full <= full_next;
      if (out_corner.valid && out_corner.ready) begin
        if (rd_last) begin
          rbank <= !rbank;
          ridx  <= '0;
        end else begin
          ridx <= ridx + 3'd1;
        end
      end
      if (wr && res.idx == 3'd7) begin
        wbank <= !wbank;
      end
    end
  end

  always_comb begin
    out_corner.valid = full[rbank];
    out_corner.last  = rd_last;
    if (bskip[rbank]) begin
      out_corner.corner_index = '0;
      out_corner.pixel_u      = '0;
      out_corner.pixel_v      = '0;
      out_corner.skipped      = 1'b1;
    end else begin
      out_corner.corner_index = ridx;
      out_corner.pixel_u      = bu[rbank][ridx];
      out_corner.pixel_v      = bv[rbank][ridx];
      out_corner.skipped      = 1'b0;
    end
  end

endmodule
